// ===== design/mkns_pkg.sv =====
// Package for the multi-key null-aware sorter.
// Holds request, status and register codes, and the control struct that the top level
// broadcasts to every storage cell. Depends on nothing.
`default_nettype none

package mkns_pkg;

  localparam int KEY_SLOTS = 4;
  localparam int KEY_W     = 32;
  localparam int IDX_W     = 6;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_PULL = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_ROW   = 2'd0,
    ST_END   = 2'd1,
    ST_FULL  = 2'd2,
    ST_SPARE = 2'd3
  } status_t;

  typedef enum logic {
    REG_KEYS_IN_USE = 1'b0,
    REG_ASC_MASK    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                 push;
    logic                 pull;
    logic [KEY_SLOTS-1:0] key_en;
    logic [KEY_SLOTS-1:0] asc;
  } mkns_ctl_t;

endpackage

`default_nettype wire

// ===== design/multi_key_null_aware_sorter.sv =====
// Top level of the multi-key null-aware sorter.
// Builds the chain of mkns_cell storage cells and the row count, arrival numbering
// and configuration registers around it. Depends on mkns_pkg and mkns_cell.
//
// Usage: a request is taken at a rising edge where start is high and busy is low;
// busy is always low, so one request can be taken in every cycle. req_type selects
// a push of a row (key_zero to key_three, null_mask) or a pull of the least row.
// Every cell compares the pushed row against its own row in the same cycle, and the
// rows behind the insertion point shift one cell along at the same clock edge; the
// comparison in each cell and the insertion flag that ripples along the chain set
// the clock period.
// A pull, or a push into a full store, gives one result: result_valid is high for
// exactly one cycle, the cycle after the request, with row_index and status. The
// receiver cannot stall, so that transfer is always taken. A successful push gives
// no result. A pull from an empty store reports end of table and restarts the
// arrival numbering at zero.
// The configuration port (cfg_write, cfg_index, cfg_data) writes keys_in_use and
// ascending_mask; rows already held keep their places.
// Reset empties the store, zeroes the arrival numbering and sets keys_in_use to 1
// and ascending_mask to all ones. No clearing pass is needed.
`default_nettype none

module multi_key_null_aware_sorter #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_KEYS = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        req_type,
  input  wire logic [mkns_pkg::KEY_W-1:0]  key_zero,
  input  wire logic [mkns_pkg::KEY_W-1:0]  key_one,
  input  wire logic [mkns_pkg::KEY_W-1:0]  key_two,
  input  wire logic [mkns_pkg::KEY_W-1:0]  key_three,
  input  wire logic [3:0]                  null_mask,
  input  wire logic                        cfg_write,
  input  wire logic                        cfg_index,
  input  wire logic [3:0]                  cfg_data,
  output logic                             result_valid,
  output logic [mkns_pkg::IDX_W-1:0]       row_index,
  output logic [1:0]                       status
);
  import mkns_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  logic [CNT_W-1:0] rows_held;
  logic [IDX_W-1:0] next_arrival;
  logic [2:0]       keys_in_use;
  logic [3:0]       ascending_mask;

  logic      accept;
  logic      full;
  logic      empty;
  logic      push_ok;
  logic      pull_ok;
  mkns_ctl_t ctl;

  logic [KEY_SLOTS-1:0][KEY_W-1:0] all_keys;
  logic [MAX_KEYS-1:0][KEY_W-1:0]  new_keys;
  logic [MAX_KEYS-1:0]             new_nulls;

  logic [MAX_KEYS-1:0][KEY_W-1:0] c_keys  [MAX_ROWS];
  logic [MAX_KEYS-1:0]            c_nulls [MAX_ROWS];
  logic [IDX_W-1:0]               c_idx   [MAX_ROWS];
  logic [MAX_ROWS-1:0]            c_ins;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (rows_held == CNT_W'(MAX_ROWS));
  assign empty  = (rows_held == '0);
  assign push_ok = accept && (req_type == REQ_PUSH) && !full;
  assign pull_ok = accept && (req_type == REQ_PULL) && !empty;

  assign all_keys = {key_three, key_two, key_one, key_zero};

  always_comb begin
    for (int i = 0; i < MAX_KEYS; i++) begin
      new_keys[i]  = all_keys[i];
      new_nulls[i] = null_mask[i];
    end
  end

  always_comb begin
    ctl.push = push_ok;
    ctl.pull = pull_ok;
    ctl.asc  = ascending_mask;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      ctl.key_en[i] = (i < MAX_KEYS) && (keys_in_use > 3'(i));
    end
  end

  for (genvar c = 0; c < MAX_ROWS; c++) begin : g_cell
    logic                           l_ins;
    logic [MAX_KEYS-1:0][KEY_W-1:0] l_keys;
    logic [MAX_KEYS-1:0]            l_nulls;
    logic [IDX_W-1:0]               l_idx;
    logic [MAX_KEYS-1:0][KEY_W-1:0] r_keys;
    logic [MAX_KEYS-1:0]            r_nulls;
    logic [IDX_W-1:0]               r_idx;
    logic                           occ;

    if (c == 0) begin : g_head
      assign l_ins   = 1'b0;
      assign l_keys  = new_keys;
      assign l_nulls = new_nulls;
      assign l_idx   = next_arrival;
    end else begin : g_body
      assign l_ins   = c_ins[c-1];
      assign l_keys  = c_keys[c-1];
      assign l_nulls = c_nulls[c-1];
      assign l_idx   = c_idx[c-1];
    end

    if (c == MAX_ROWS - 1) begin : g_tail
      assign r_keys  = c_keys[c];
      assign r_nulls = c_nulls[c];
      assign r_idx   = c_idx[c];
    end else begin : g_inner
      assign r_keys  = c_keys[c+1];
      assign r_nulls = c_nulls[c+1];
      assign r_idx   = c_idx[c+1];
    end

    assign occ = (rows_held > CNT_W'(c));

    mkns_cell #(
      .MAX_KEYS(MAX_KEYS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .new_keys   (new_keys),
      .new_nulls  (new_nulls),
      .new_idx    (next_arrival),
      .left_ins   (l_ins),
      .left_keys  (l_keys),
      .left_nulls (l_nulls),
      .left_idx   (l_idx),
      .right_keys (r_keys),
      .right_nulls(r_nulls),
      .right_idx  (r_idx),
      .ins        (c_ins[c]),
      .keys       (c_keys[c]),
      .nulls      (c_nulls[c]),
      .idx        (c_idx[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_held    <= '0;
      next_arrival <= '0;
    end else if (push_ok) begin
      rows_held    <= rows_held + CNT_W'(1);
      next_arrival <= next_arrival + IDX_W'(1);
    end else if (pull_ok) begin
      rows_held <= rows_held - CNT_W'(1);
    end else if (accept && (req_type == REQ_PULL)) begin
      next_arrival <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_in_use    <= 3'd1;
      ascending_mask <= 4'hF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEYS_IN_USE: keys_in_use    <= cfg_data[2:0];
        REG_ASC_MASK:    ascending_mask <= cfg_data;
        default:         keys_in_use    <= keys_in_use;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept && ((req_type == REQ_PULL) || full);
    end
  end

  always_ff @(posedge clk) begin
    if (pull_ok) begin
      row_index <= c_idx[0];
      status    <= ST_ROW;
    end else if (req_type == REQ_PULL) begin
      row_index <= '0;
      status    <= ST_END;
    end else begin
      row_index <= '0;
      status    <= ST_FULL;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rows_held <= CNT_W'(MAX_ROWS))
    else $error("row count exceeds store depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> rows_held == $past(rows_held) + CNT_W'(1))
    else $error("accepted push did not add a row");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_PUSH) && !full |=> !result_valid)
    else $error("successful push produced a result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_PUSH) && full |=> result_valid && status == ST_FULL)
    else $error("push into full store not flagged");

endmodule

`default_nettype wire

// ===== design/mkns_cell.sv =====
// One storage cell of the sorted insertion chain.
// Holds one row, compares an incoming row against it and shifts rows toward its
// neighbors on insertion and removal. Depends on mkns_pkg.
`default_nettype none

module mkns_cell #(
  parameter int MAX_KEYS = 4
) (
  input  wire logic                                    clk,
  input  wire mkns_pkg::mkns_ctl_t                     ctl,
  input  wire logic                                    occ,
  input  wire logic [MAX_KEYS-1:0][mkns_pkg::KEY_W-1:0] new_keys,
  input  wire logic [MAX_KEYS-1:0]                     new_nulls,
  input  wire logic [mkns_pkg::IDX_W-1:0]              new_idx,
  input  wire logic                                    left_ins,
  input  wire logic [MAX_KEYS-1:0][mkns_pkg::KEY_W-1:0] left_keys,
  input  wire logic [MAX_KEYS-1:0]                     left_nulls,
  input  wire logic [mkns_pkg::IDX_W-1:0]              left_idx,
  input  wire logic [MAX_KEYS-1:0][mkns_pkg::KEY_W-1:0] right_keys,
  input  wire logic [MAX_KEYS-1:0]                     right_nulls,
  input  wire logic [mkns_pkg::IDX_W-1:0]              right_idx,
  output logic                                         ins,
  output logic [MAX_KEYS-1:0][mkns_pkg::KEY_W-1:0]     keys,
  output logic [MAX_KEYS-1:0]                          nulls,
  output logic [mkns_pkg::IDX_W-1:0]                   idx
);
  import mkns_pkg::*;

  logic new_first;

  // Later keys are overwritten by earlier ones, so the first deciding key wins.
  always_comb begin
    new_first = 1'b0;
    for (int i = MAX_KEYS - 1; i >= 0; i--) begin
      if (ctl.key_en[i]) begin
        if (new_nulls[i] && nulls[i]) begin
          new_first = new_first;
        end else if (new_nulls[i]) begin
          new_first = ctl.asc[i];
        end else if (nulls[i]) begin
          new_first = !ctl.asc[i];
        end else if (new_keys[i] != keys[i]) begin
          new_first = ctl.asc[i] ? ($signed(new_keys[i]) < $signed(keys[i]))
                                 : ($signed(new_keys[i]) > $signed(keys[i]));
        end
      end
    end
  end

  // Once a cell to the left has taken the new row, every later cell shifts.
  assign ins = left_ins || !occ || new_first;

  always_ff @(posedge clk) begin
    if (ctl.pull) begin
      keys  <= right_keys;
      nulls <= right_nulls;
      idx   <= right_idx;
    end else if (ctl.push && left_ins) begin
      keys  <= left_keys;
      nulls <= left_nulls;
      idx   <= left_idx;
    end else if (ctl.push && ins) begin
      keys  <= new_keys;
      nulls <= new_nulls;
      idx   <= new_idx;
    end
  end

endmodule

`default_nettype wire
